>>> design/scalar_kalman_window_noise_defines.svh
// assertion macros for the scalar kalman window noise block
// no dependencies; included by the checker
`ifndef SCALAR_KALMAN_WINDOW_NOISE_DEFINES_SVH
`define SCALAR_KALMAN_WINDOW_NOISE_DEFINES_SVH

// same-cycle implication, masked during reset
`define SKW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define SKW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/skw_pkg.sv
// shared types and constants of the scalar kalman window noise block
// no dependencies
package skw_pkg;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned COV_W       = 31;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned MUL_W       = 35;
    localparam int unsigned DIV_W       = 64;
    localparam int unsigned SQ_W        = 48;
    localparam int unsigned GAIN_W      = 17;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned RECIP_SHIFT = 37;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV = 8'd1;

    localparam logic [COV_W-1:0]  COV_RESET = 31'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
    // reciprocal of 100 scaled by 2^37
    localparam logic [MUL_W-1:0]  RECIP_100 = 35'd1374389535;
    localparam logic [DATA_W:0]   ROUND_100 = 33'd50;

    // classified request handed from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] res;
        logic signed [DATA_W-1:0] target;
        logic                     meas_neg;
        logic [DATA_W:0]          meas_bias;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;
endpackage

>>> design/skw_if.sv
// handshake channels of the scalar kalman window noise block
// depends on skw_pkg
interface skw_in_if import skw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] measured_value;
    logic signed [DATA_W-1:0] command_value;
    modport source (output valid, measured_value, command_value, input ready);
    modport sink   (input valid, measured_value, command_value, output ready);
endinterface

interface skw_out_if import skw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered_estimate;
    logic [COV_W-1:0]         error_covariance;
    modport source (output valid, filtered_estimate, error_covariance, input ready);
    modport sink   (input valid, filtered_estimate, error_covariance, output ready);
endinterface

>>> design/scalar_kalman_window_noise.sv
// top level of the scalar kalman window noise filter
// depends on skw_pkg, skw_if, skw_front, skw_queue, skw_back
//
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   measured_value, command_value (Q16.16 signed)
//  o_out     out  valid/ready   filtered_estimate (Q16.16), error_covariance (31 bit)
//  i_cfg_*   in   write enable  index 0 initial_estimate, 1 initial_covariance
//
// each request runs through window update and noise estimates, the 64-step gain divider
// and the estimate and covariance update; the divider is skipped when the divisor is zero
// the front takes up to two requests into its queue while the back is busy
// a stalled output holds in its register; the back waits only to load it
// reset is synchronous; window entries read as zero until the slot first wraps
// the window length must be a power of two; the block itself does not enforce it
module scalar_kalman_window_noise import skw_pkg::*; #(
    parameter int unsigned WINDOW_LEN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    skw_in_if.sink               i_in,
    skw_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data
);
    logic  w_push, w_full, w_q_valid, w_q_pop;
    t_item w_push_item, w_q_item;

    // classification
    skw_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    // decoupling queue
    skw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // filter engine
    skw_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );
endmodule

>>> design/skw_ram.sv
// generic single-write ram with registered read
// no dependencies
module skw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/skw_queue.sv
// short queue between front and back
// depends on skw_pkg
module skw_queue import skw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);
    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_item    = r_slots[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slots[r_wptr] <= i_item;
        end
    end
endmodule

>>> design/skw_div.sv
// restoring divider, one quotient bit per cycle
// depends on skw_pkg
module skw_div import skw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem, r_quo, r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DIV_W:0]   w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? DIV_W'(w_trial - {1'b0, r_dvs}) : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

>>> design/skw_front.sv
// front: accepts requests and forms residual, target and measurement magnitude
// depends on skw_pkg, skw_if
module skw_front import skw_pkg::*; (
    skw_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_item  o_item
);
    logic signed [DATA_W:0]   w_diff;
    logic signed [DATA_W-1:0] w_res;
    logic signed [DATA_W:0]   w_target;
    logic [DATA_W-1:0]        w_mag;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // half difference, floored
    assign w_diff   = (DATA_W + 1)'(i_in.measured_value) - (DATA_W + 1)'(i_in.command_value);
    assign w_res    = w_diff[DATA_W:1];
    assign w_target = (DATA_W + 1)'(i_in.command_value) + (DATA_W + 1)'(w_res);
    assign w_mag    = i_in.measured_value[DATA_W-1] ? DATA_W'(-i_in.measured_value)
                                                    : DATA_W'(i_in.measured_value);

    assign o_item.res       = w_res;
    assign o_item.target    = w_target[DATA_W-1:0];
    assign o_item.meas_neg  = i_in.measured_value[DATA_W-1];
    assign o_item.meas_bias = {1'b0, w_mag} + ROUND_100;
endmodule

>>> design/skw_back.sv
// back: window update, noise estimates, gain and state update
// depends on skw_pkg, skw_if, skw_ram, skw_div
module skw_back import skw_pkg::*; #(
    parameter int unsigned WINDOW_LEN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    skw_out_if.source            o_out
);
    // window length is a power of two, so the window mean is a shift by SLOT_W
    localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
    localparam int unsigned SUM_W  = DATA_W + 1 + $clog2(WINDOW_LEN);
    localparam int unsigned SQS_W  = SQ_W + $clog2(WINDOW_LEN);
    localparam int unsigned ENT_W  = DATA_W + SQ_W;
    localparam int unsigned PROD_W = 2 * MUL_W;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_MUL_PROC = 11'b00000000010,
        ST_MUL_RSQ  = 11'b00000000100,
        ST_MUL_PSQ  = 11'b00000001000,
        ST_WRITE    = 11'b00000010000,
        ST_VAR_R    = 11'b00000100000,
        ST_VAR_P    = 11'b00001000000,
        ST_DIV_K    = 11'b00010000000,
        ST_MUL_X    = 11'b00100000000,
        ST_MUL_P    = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    t_item                    r_item;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_wrapped;
    logic signed [DATA_W-1:0] r_old_res, r_old_proc, r_proc;
    logic [SQ_W-1:0]          r_old_rsq, r_old_psq, r_rsq_new;
    logic signed [SUM_W-1:0]  r_rsum, r_psum;
    logic [SQS_W-1:0]         r_rsqs, r_psqs;
    logic [DIV_W-1:0]         r_rvar, r_pp;
    logic [GAIN_W-1:0]        r_k;
    logic signed [DATA_W-1:0] r_est;
    logic [COV_W-1:0]         r_cov;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_dneg;
    logic                     r_ovalid;
    logic signed [DATA_W-1:0] r_oest;
    logic [COV_W-1:0]         r_ocov;

    logic [MUL_W-1:0]         w_mul_a, w_mul_b;
    logic [ENT_W-1:0]         w_res_rd, w_proc_rd;
    logic                     w_ram_we;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;
    logic [DATA_W-1:0]        w_res_mag, w_proc_mag, w_pm;
    logic [SQ_W-1:0]          w_sq_new, w_msq;
    logic [SUM_W-1:0]         w_rsum_mag, w_psum_mag;
    logic [DATA_W:0]          w_rmean, w_pmean;
    logic [SQ_W-1:0]          w_ravg, w_pavg, w_avg;
    logic [DIV_W-1:0]         w_var, w_pp, w_den;
    logic signed [MUL_W:0]    w_diff;
    logic [MUL_W-1:0]         w_diff_mag;
    logic [PROD_W-1:0]        w_rnd;
    logic signed [MUL_W+1:0]  w_x;
    logic signed [DATA_W-1:0] w_x_sat;
    logic [PROD_W-17:0]       w_p;
    logic [COV_W-1:0]         w_p_sat;
    logic                     w_out_free;

    // window stores: value and its scaled square per entry
    skw_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_LEN)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata ({r_item.res, r_rsq_new}),
        .i_raddr (r_slot),
        .o_rdata (w_res_rd)
    );

    skw_ram #(.WIDTH(ENT_W), .DEPTH(WINDOW_LEN)) u_proc_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata ({r_proc, w_sq_new}),
        .i_raddr (r_slot),
        .o_rdata (w_proc_rd)
    );

    skw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // derived values
    assign w_ram_we   = (r_state == ST_WRITE);
    assign w_res_mag  = r_item.res[DATA_W-1] ? DATA_W'(-r_item.res) : DATA_W'(r_item.res);
    assign w_proc_mag = r_proc[DATA_W-1] ? DATA_W'(-r_proc) : DATA_W'(r_proc);
    assign w_pm       = r_prod[RECIP_SHIFT +: DATA_W];
    assign w_sq_new   = r_prod[16 +: SQ_W];
    assign w_msq      = r_prod[16 +: SQ_W];
    assign w_rsum_mag = r_rsum[SUM_W-1] ? SUM_W'(-r_rsum) : SUM_W'(r_rsum);
    assign w_psum_mag = r_psum[SUM_W-1] ? SUM_W'(-r_psum) : SUM_W'(r_psum);

    // window means and mean squares by shifting out the window length
    assign w_rmean    = w_rsum_mag[SUM_W-1:SLOT_W];
    assign w_pmean    = w_psum_mag[SUM_W-1:SLOT_W];
    assign w_ravg     = r_rsqs[SQS_W-1:SLOT_W];
    assign w_pavg     = r_psqs[SQS_W-1:SLOT_W];
    assign w_avg      = (r_state == ST_VAR_R) ? w_ravg : w_pavg;
    assign w_var      = (w_avg > w_msq) ? DIV_W'(w_avg - w_msq) : '0;

    assign w_pp       = DIV_W'(r_cov) + w_var;
    assign w_den      = w_pp + r_rvar;
    assign w_diff     = (MUL_W + 1)'(r_item.target) - (MUL_W + 1)'(r_est);
    assign w_diff_mag = w_diff[MUL_W] ? MUL_W'(-w_diff) : MUL_W'(w_diff);
    assign w_rnd      = r_prod + PROD_W'(32768);
    assign w_out_free = !r_ovalid || o_out.ready;

    // estimate step with saturation
    always_comb begin
        w_x = r_dneg ? (MUL_W + 2)'(r_est) - (MUL_W + 2)'(w_rnd[16 +: MUL_W])
                     : (MUL_W + 2)'(r_est) + (MUL_W + 2)'(w_rnd[16 +: MUL_W]);
        if (w_x > (MUL_W + 2)'(32'sh7FFFFFFF)) begin
            w_x_sat = 32'sh7FFFFFFF;
        end else if (w_x < -(MUL_W + 2)'(33'sh080000000)) begin
            w_x_sat = 32'sh80000000;
        end else begin
            w_x_sat = w_x[DATA_W-1:0];
        end
    end

    // covariance rounding and saturation
    assign w_p     = w_rnd[PROD_W-1:16];
    assign w_p_sat = (w_p > (PROD_W - 16)'(31'h7FFFFFFF)) ? 31'h7FFFFFFF : w_p[COV_W-1:0];

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_MUL_PROC: begin
                w_mul_a = MUL_W'(r_item.meas_bias);
                w_mul_b = RECIP_100;
            end
            ST_MUL_RSQ: begin
                w_mul_a = MUL_W'(w_res_mag);
                w_mul_b = MUL_W'(w_res_mag);
            end
            ST_MUL_PSQ: begin
                w_mul_a = MUL_W'(w_proc_mag);
                w_mul_b = MUL_W'(w_proc_mag);
            end
            ST_WRITE: begin
                w_mul_a = MUL_W'(w_rmean);
                w_mul_b = MUL_W'(w_rmean);
            end
            ST_VAR_R: begin
                w_mul_a = MUL_W'(w_pmean);
                w_mul_b = MUL_W'(w_pmean);
            end
            ST_MUL_X: begin
                w_mul_a = w_diff_mag;
                w_mul_b = MUL_W'(r_k);
            end
            ST_MUL_P, ST_DONE: begin
                w_mul_a = MUL_W'(GAIN_ONE - r_k);
                w_mul_b = r_pp[MUL_W-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // gain division request and next state
    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_MUL_PROC;
                end
            end
            ST_MUL_PROC: n_state = ST_MUL_RSQ;
            ST_MUL_RSQ:  n_state = ST_MUL_PSQ;
            ST_MUL_PSQ:  n_state = ST_WRITE;
            ST_WRITE:    n_state = ST_VAR_R;
            ST_VAR_R:    n_state = ST_VAR_P;
            ST_VAR_P: begin
                if (w_den == '0) begin
                    n_state = ST_MUL_X;
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = {w_pp[DIV_W-17:0], 16'd0};
                    w_div_req.divisor  = w_den;
                    n_state            = ST_DIV_K;
                end
            end
            ST_DIV_K: begin
                if (w_div_rsp.done) begin
                    n_state = ST_MUL_X;
                end
            end
            ST_MUL_X: n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_q_pop = (r_state == ST_IDLE);

    // control state, window bookkeeping and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= '0;
            r_wrapped <= 1'b0;
            r_rsum    <= '0;
            r_psum    <= '0;
            r_rsqs    <= '0;
            r_psqs    <= '0;
            r_est     <= '0;
            r_cov     <= COV_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL_PSQ) begin
                r_rsum <= r_rsum + SUM_W'(r_item.res) - SUM_W'(r_old_res);
                r_rsqs <= r_rsqs + SQS_W'(w_sq_new) - SQS_W'(r_old_rsq);
            end
            if (r_state == ST_WRITE) begin
                r_psum <= r_psum + SUM_W'(r_proc) - SUM_W'(r_old_proc);
                r_psqs <= r_psqs + SQS_W'(w_sq_new) - SQS_W'(r_old_psq);
                if (r_slot == SLOT_W'(WINDOW_LEN - 1)) begin
                    r_slot    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (r_state == ST_MUL_P) begin
                r_est <= w_x_sat;
            end
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_cov    <= w_p_sat;
                r_ovalid <= 1'b1;
            end
            // register writes load the filter state directly
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_INIT_EST) begin
                    r_est <= i_cfg_data;
                end else if (i_cfg_idx == CFG_INIT_COV) begin
                    r_cov <= i_cfg_data[COV_W-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (r_state == ST_IDLE && i_q_valid) begin
            r_item <= i_q_item;
        end
        // entries not yet written since reset read as zero
        if (r_state == ST_MUL_PROC) begin
            r_old_res  <= r_wrapped ? w_res_rd[ENT_W-1 -: DATA_W] : '0;
            r_old_rsq  <= r_wrapped ? w_res_rd[SQ_W-1:0] : '0;
            r_old_proc <= r_wrapped ? w_proc_rd[ENT_W-1 -: DATA_W] : '0;
            r_old_psq  <= r_wrapped ? w_proc_rd[SQ_W-1:0] : '0;
        end
        if (r_state == ST_MUL_RSQ) begin
            r_proc <= r_item.meas_neg ? DATA_W'(-w_pm) : w_pm;
        end
        if (r_state == ST_MUL_PSQ) begin
            r_rsq_new <= w_sq_new;
        end
        if (r_state == ST_VAR_R) begin
            r_rvar <= w_var;
        end
        if (r_state == ST_VAR_P) begin
            r_pp <= w_pp;
            r_k  <= '0;
        end
        if (r_state == ST_DIV_K && w_div_rsp.done) begin
            r_k <= w_div_rsp.quotient[GAIN_W-1:0];
        end
        if (r_state == ST_MUL_X) begin
            r_dneg <= w_diff[MUL_W];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_oest <= r_est;
            r_ocov <= w_p_sat;
        end
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.filtered_estimate = r_oest;
    assign o_out.error_covariance  = r_ocov;
endmodule

>>> design/skw_checker.sv
// port-level checks of the scalar kalman window noise filter
// depends on scalar_kalman_window_noise_defines.svh; bound to the top level
`include "scalar_kalman_window_noise_defines.svh"

module skw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_est,
    input logic [30:0] i_out_cov
);
    logic [2:0] r_cnt;

    // requests taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'((i_in_valid && i_in_ready) ? 1 : 0)
                           - 3'((i_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    `SKW_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `SKW_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready,
        $stable(i_out_est) && $stable(i_out_cov), "stalled result changed")
    `SKW_ASSERT_IMP(a_no_orphan, i_out_valid, r_cnt != 3'd0, "result without request")
    `SKW_ASSERT_IMP(a_bound, 1'b1, r_cnt <= 3'd4, "too many requests in flight")
endmodule

bind scalar_kalman_window_noise skw_checker u_skw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_est   (o_out.filtered_estimate),
    .i_out_cov   (o_out.error_covariance)
);

>>> tb/skw_checker.sv
`timescale 1ns / 1ps
// result checker of the scalar kalman window noise filter: watches both channels and
// the register port, predicts each result and compares; depends on skw_pkg and skw_if
module skw_result_checker import skw_pkg::*; #(
    parameter int unsigned WINDOW_LEN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    skw_in_if                    i_in,
    skw_out_if                   i_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results
);
    typedef struct packed {
        logic signed [DATA_W-1:0] est;
        logic [COV_W-1:0]         cov;
    } t_estimate;

    t_estimate       estimate_q[$];
    longint          res_win[WINDOW_LEN];
    longint          proc_win[WINDOW_LEN];
    longint          res_sum;
    longint          proc_sum;
    logic [63:0]     res_sq_sum;
    logic [63:0]     proc_sq_sum;
    longint          est_state;
    logic [63:0]     cov_state;
    int unsigned     slot;

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] square_q16(input longint v);
        logic [63:0] a;
        a = magnitude(v);
        return (a * a) >> 16;
    endfunction

    function automatic logic [63:0] window_variance(input longint s1, input logic [63:0] s2);
        logic [63:0] mean;
        logic [63:0] mean_sq;
        logic [63:0] avg_sq;
        mean    = magnitude(s1) / WINDOW_LEN;
        mean_sq = (mean * mean) >> 16;
        avg_sq  = s2 / WINDOW_LEN;
        return (avg_sq > mean_sq) ? avg_sq - mean_sq : 64'd0;
    endfunction

    // one filter update: window bookkeeping, noise estimates, gain, estimate and covariance
    function automatic t_estimate kalman_update(input logic signed [DATA_W-1:0] meas,
                                                input logic signed [DATA_W-1:0] cmd);
        longint      m;
        longint      c;
        longint      d;
        longint      res;
        longint      proc;
        longint      z;
        longint      diff;
        longint      x;
        logic [63:0] pm;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] pp;
        logic [63:0] den;
        logic [63:0] k;
        logic [63:0] step;
        logic [63:0] p;
        t_estimate   outv;
        m    = longint'(meas);
        c    = longint'(cmd);
        d    = m - c;
        res  = (d < 0) ? -longint'((magnitude(d) + 1) >> 1) : longint'(magnitude(d) >> 1);
        pm   = (magnitude(m) + 50) / 100;
        proc = (m < 0) ? -longint'(pm) : longint'(pm);

        res_sum       += res - res_win[slot];
        res_sq_sum     = res_sq_sum - square_q16(res_win[slot]) + square_q16(res);
        res_win[slot]  = res;
        proc_sum      += proc - proc_win[slot];
        proc_sq_sum    = proc_sq_sum - square_q16(proc_win[slot]) + square_q16(proc);
        proc_win[slot] = proc;

        z   = c + res;
        r   = window_variance(res_sum, res_sq_sum);
        q   = window_variance(proc_sum, proc_sq_sum);
        pp  = cov_state + q;
        den = pp + r;
        k   = (den == 0) ? 64'd0 : (pp << 16) / den;

        diff = z - est_state;
        step = (magnitude(diff) * k + 64'd32768) >> 16;
        x    = (diff < 0) ? est_state - longint'(step) : est_state + longint'(step);
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        est_state = x;

        p = ((64'd65536 - k) * pp + 64'd32768) >> 16;
        if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
        cov_state = p;

        slot     = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
        outv.est = est_state[DATA_W-1:0];
        outv.cov = cov_state[COV_W-1:0];
        return outv;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    // everything settles at the rising edge, so the state just before it is sampled here
    always @(negedge i_clk) begin
        t_estimate want;
        if (!i_rst_n) begin
            foreach (res_win[i]) begin
                res_win[i]  = 0;
                proc_win[i] = 0;
            end
            res_sum     = 0;
            proc_sum    = 0;
            res_sq_sum  = 0;
            proc_sq_sum = 0;
            slot        = 0;
            est_state   = 0;
            cov_state   = 64'(COV_RESET);
            estimate_q.delete();
        end else begin
            // register writes load the live state at once
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_EST: est_state = longint'(signed'(i_cfg_data));
                    CFG_INIT_COV: cov_state = 64'(i_cfg_data[COV_W-1:0]);
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                estimate_q.push_back(kalman_update(i_in.measured_value, i_in.command_value));
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (estimate_q.size() == 0) begin
                    $display("%0t result with no request outstanding", $time);
                    o_errors++;
                end else begin
                    want = estimate_q.pop_front();
                    if (i_out.filtered_estimate !== want.est)
                        report_mismatch("filtered_estimate", longint'(i_out.filtered_estimate),
                                        longint'(want.est));
                    if (i_out.error_covariance !== want.cov)
                        report_mismatch("error_covariance", longint'(i_out.error_covariance),
                                        longint'(want.cov));
                end
            end
        end
        o_pending = estimate_q.size();
    end

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_pending = 0;
    end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the scalar kalman window noise filter
// depends on skw_pkg, skw_if, skw_checker and the block itself
module tb;
    import skw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 320;
    localparam int HOLD_CYCLES   = 3000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;
    int                   errors;
    int                   pending;
    int                   results;
    int                   requests_sent;
    bit                   gaps_on;
    bit                   hold_req;

    skw_in_if  in_ch ();
    skw_out_if out_ch ();

    scalar_kalman_window_noise u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    skw_result_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

    // output side: random stalls, one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering requests and wait for every result to drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one request; returns at the edge that took it, or after a pause that may follow it when gaps are on
    task automatic send_request(input logic signed [DATA_W-1:0] meas,
                                input logic signed [DATA_W-1:0] cmd);
        bit took;
        in_ch.valid          <= 1'b1;
        in_ch.measured_value <= meas;
        in_ch.command_value  <= cmd;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end
        requests_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return DATA_W'(signed'($urandom_range(0, 1 << 19)) - (1 << 18));
            2: return DATA_W'(signed'($urandom_range(0, 4096)) - 2048);
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                 : 32'sh8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_request();
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] c;
        m = pick_value();
        // mostly a command tracking the measurement, sometimes unrelated
        if ($urandom_range(0, 2) != 0) c = m + DATA_W'(signed'($urandom_range(0, 8192)) - 4096);
        else c = pick_value();
        send_request(m, c);
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.measured_value = '0;
        in_ch.command_value  = '0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        i_rst_n              = 1'b0;
        gaps_on              = 1'b1;
        hold_req             = 1'b0;
        requests_sent        = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero covariance with empty windows gives a zero divisor
        write_reg(CFG_INIT_COV, 32'd0);
        send_request(32'sd0, 32'sd0);
        send_request(32'sd0, 32'sd0);
        wait_idle();

        // unused indexes are ignored; covariance keeps only its low bits
        write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_TOP, 32'h1234_5678);
        write_reg(CFG_INIT_COV, 32'hFFFF_FFFF);
        write_reg(CFG_INIT_EST, 32'h7FFF_FFFF);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        wait_idle();

        // directed: rounding ties, odd negative differences, extremes
        write_reg(CFG_INIT_EST, 32'h8000_0000);
        write_reg(CFG_INIT_COV, 32'(COV_RESET));
        send_request(32'sh8000_0000, 32'sh8000_0000);
        send_request(32'sd50, 32'sd0);
        send_request(-32'sd50, 32'sd0);
        send_request(32'sd150, 32'sd151);
        send_request(-32'sd149, 32'sd0);
        send_request(32'sd1, 32'sd2);
        send_request(-32'sd3, 32'sd0);
        send_request(32'sh0001_0000, -32'sh0001_0000);
        send_request(32'shFFFF_FFFF, 32'sh5555_5555);
        send_request(32'shAAAA_AAAA, 32'sh0000_0000);
        send_request(32'sh7FFF_FFFF, -32'sd1);
        send_request(-32'sd1, 32'sh7FFF_FFFF);
        wait_idle();

        // random phases, each under its own register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_INIT_EST, 32'h0);
                    write_reg(CFG_INIT_COV, 32'h0);
                end
                1: begin
                    write_reg(CFG_INIT_EST, $urandom());
                    write_reg(CFG_INIT_COV, 32'h7FFF_FFFF);
                    hold_req = 1'b1;
                end
                2: begin
                    write_reg(CFG_INIT_EST, 32'h8000_0000);
                    write_reg(CFG_INIT_COV, $urandom());
                end
                default: begin
                    write_reg(CFG_INIT_COV, $urandom_range(0, 1 << 20));
                    gaps_on = 1'b0;
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            wait_idle();
        end

        repeat (400) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked over %0d register settings",
                 requests_sent, results, RANDOM_PHASES + 3);
        $display("directed extremes, zero divisor, ignored indexes and a long output hold run");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
